// ----- rtl/rtpl_pkg.sv -----
package rtpl_pkg;

  // Fraction bits of the exponent e, and of the mantissa inside the log and exp units.
  localparam int unsigned EXP_FRAC  = 24;
  localparam int unsigned MANT_FRAC = 30;

  typedef enum logic [2:0] {
    REG_SCALE      = 3'd0,
    REG_EXP_CONST  = 3'd1,
    REG_EXP_LINEAR = 3'd2,
    REG_EXP_SQUARE = 3'd3,
    REG_EXP_CUBE   = 3'd4,
    REG_CRIT_TEMP  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [31:0] scale;
    logic signed [31:0] c1;
    logic signed [31:0] c2;
    logic signed [31:0] c3;
    logic signed [31:0] c4;
    logic        [31:0] tc;
  } cfg_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bit_w;
    logic [63:0] rem;
    res   = '0;
    bit_w = 64'h4000_0000_0000_0000;
    rem   = v;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bit_w) begin
        rem = rem - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // 2^(2^-k) in Q1.30, built from repeated integer square roots of 2.0.
  function automatic logic [63:0] root_const(input int unsigned k);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int unsigned j = 1; j <= MANT_FRAC; j++) begin
      if (j <= k) begin
        r = isqrt64(r << MANT_FRAC);
      end
    end
    return r;
  endfunction

endpackage

// ----- rtl/reduced_temperature_power_law.sv -----
// Reduced temperature power law: value = c0 * (1 - Tr)^(c1 + c2*Tr + c3*Tr^2 + c4*Tr^3)
// with Tr = min(t/Tc, 1), clamped at zero and saturating at the top.
// Input channel: in_valid_i/in_ready_o with one Q16.16 temperature per item.
// Output channel: out_valid_o/out_ready_i with the Q16.16 result and a saturation flag.
// Configuration: cfg_valid_i with cfg_index_i/cfg_data_i; cfg_ready_o is always high.
// Indices beyond the critical temperature register are ignored. Write only while idle.
// The pipeline is made of sixteen restoring divider steps, one squaring step per
// log2 fraction bit, one conditional root multiply per exp2 fraction bit, and a
// handful of multiply and sum stages.
// Throughput is one item per cycle while the receiver keeps taking items; every stage holds a valid bit.
// When the receiver stalls, the output item holds and items behind it close up
// into empty stages, so the input keeps taking items until the pipeline is full.
// Reset empties the pipeline and loads the register defaults (Tc = 1.0, others 0).
module reduced_temperature_power_law #(
  parameter int unsigned FUNC_FRAC_BITS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] temperature_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] property_value_o,
  output logic        saturated_o
);

  rtpl_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.scale <= '0;
      cfg_q.c1    <= '0;
      cfg_q.c2    <= '0;
      cfg_q.c3    <= '0;
      cfg_q.c4    <= '0;
      cfg_q.tc    <= 32'h0001_0000;
    end else if (cfg_valid_i) begin
      unique case (rtpl_pkg::cfg_reg_e'(cfg_index_i))
        rtpl_pkg::REG_SCALE:      cfg_q.scale <= cfg_data_i;
        rtpl_pkg::REG_EXP_CONST:  cfg_q.c1    <= cfg_data_i;
        rtpl_pkg::REG_EXP_LINEAR: cfg_q.c2    <= cfg_data_i;
        rtpl_pkg::REG_EXP_SQUARE: cfg_q.c3    <= cfg_data_i;
        rtpl_pkg::REG_EXP_CUBE:   cfg_q.c4    <= cfg_data_i;
        rtpl_pkg::REG_CRIT_TEMP:  cfg_q.tc    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  rtpl_pipe #(
    .FUNC_FRAC_BITS(FUNC_FRAC_BITS)
  ) u_pipe (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .temperature_i    (temperature_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .property_value_o (property_value_o),
    .saturated_o      (saturated_o)
  );

  // A receiver that takes the output frees every stage, so the input must be open.
  a_ready_through : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input blocked while output is taken");

  a_sat_value : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && saturated_o) |-> (property_value_o == 32'hFFFF_FFFF))
    else $error("saturated item without full-scale value");

endmodule

// ----- rtl/rtpl_pipe.sv -----
module rtpl_pipe #(
  parameter int unsigned FUNC_FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rtpl_pkg::cfg_t       cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [31:0]          temperature_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          property_value_o,
  output logic                 saturated_o
);

  localparam int unsigned F         = FUNC_FRAC_BITS;
  localparam int unsigned XF        = rtpl_pkg::EXP_FRAC;
  localparam int unsigned MF        = rtpl_pkg::MANT_FRAC;
  localparam int unsigned LW        = ((F > XF) ? F : XF) + 6;
  localparam int unsigned HW        = LW - XF;
  localparam int unsigned YW        = 32 + HW + 1;
  localparam int unsigned NW        = YW - F;
  localparam int unsigned DIV_STEPS = 16;
  localparam int unsigned ST_DIV0   = 1;
  localparam int unsigned ST_TR     = ST_DIV0 + DIV_STEPS;
  localparam int unsigned ST_TR3    = ST_TR + 1;
  localparam int unsigned ST_PRD    = ST_TR + 2;
  localparam int unsigned ST_SUM    = ST_TR + 3;
  localparam int unsigned ST_NRM    = ST_TR + 4;
  localparam int unsigned ST_LOG0   = ST_TR + 5;
  localparam int unsigned ST_Y1     = ST_LOG0 + F;
  localparam int unsigned ST_Y2     = ST_Y1 + 1;
  localparam int unsigned ST_EXP0   = ST_Y1 + 2;
  localparam int unsigned ST_MUL    = ST_EXP0 + F;
  localparam int unsigned ST_OUT    = ST_MUL + 1;
  localparam int unsigned NST       = ST_OUT + 1;

  typedef struct packed {
    logic                   big;
    logic [32:0]            rem;
    logic [15:0]            quo;
    logic [16:0]            tr;
    logic [16:0]            tr2;
    logic [16:0]            tr3;
    logic signed [49:0]     p1;
    logic signed [49:0]     p2;
    logic signed [49:0]     p3;
    logic signed [31:0]     e;
    logic [16:0]            x;
    logic [4:0]             lp;
    logic [30:0]            lm;
    logic [F-1:0]           frac;
    logic signed [31+HW:0]  pa;
    logic signed [56:0]     pb;
    logic signed [NW-1:0]   n;
    logic [F-1:0]           f;
    logic                   nbig;
    logic [30:0]            em;
    logic [63:0]            prod;
    logic [31:0]            val;
    logic                   sat;
  } stage_t;

  stage_t         st_q [NST];
  stage_t         st_d [NST];
  logic [NST-1:0] v_q;
  logic [NST-1:0] vin;
  logic [NST:0]   en;

  assign vin         = {v_q[NST-2:0], in_valid_i};
  assign en[NST]     = out_ready_i;
  assign in_ready_o  = en[0];

  for (genvar k = 0; k < NST; k++) begin : g_stage
    // A stage takes a new item when it is empty or its own item moves on.
    assign en[k] = !v_q[k] || en[k+1];

    if (k == 0) begin : g_ent
      stage_t d;
      always_comb begin
        d     = '0;
        d.big = (cfg_i.tc == 32'd0) || (temperature_i >= cfg_i.tc);
        d.rem = {1'b0, temperature_i};
      end
      assign st_d[k] = d;
    end else if (k < ST_TR) begin : g_div
      stage_t      d;
      stage_t      s;
      logic [32:0] r2;
      logic        ge;
      assign s = st_q[k-1];
      always_comb begin
        r2    = {s.rem[31:0], 1'b0};
        ge    = r2 >= {1'b0, cfg_i.tc};
        d     = s;
        d.rem = ge ? r2 - {1'b0, cfg_i.tc} : r2;
        d.quo = {s.quo[14:0], ge};
      end
      assign st_d[k] = d;
    end else if (k == ST_TR) begin : g_tr
      stage_t      d;
      stage_t      s;
      logic [33:0] sq;
      assign s = st_q[k-1];
      always_comb begin
        d     = s;
        d.tr  = s.big ? 17'h10000 : {1'b0, s.quo};
        sq    = 34'(d.tr) * 34'(d.tr);
        d.tr2 = sq[32:16];
      end
      assign st_d[k] = d;
    end else if (k == ST_TR3) begin : g_tr3
      stage_t      d;
      stage_t      s;
      logic [33:0] cu;
      assign s = st_q[k-1];
      always_comb begin
        d     = s;
        cu    = 34'(s.tr2) * 34'(s.tr);
        d.tr3 = cu[32:16];
        d.p1  = cfg_i.c2 * $signed({1'b0, s.tr});
      end
      assign st_d[k] = d;
    end else if (k == ST_PRD) begin : g_prd
      stage_t d;
      stage_t s;
      assign s = st_q[k-1];
      always_comb begin
        d    = s;
        d.p2 = cfg_i.c3 * $signed({1'b0, s.tr2});
        d.p3 = cfg_i.c4 * $signed({1'b0, s.tr3});
      end
      assign st_d[k] = d;
    end else if (k == ST_SUM) begin : g_sum
      stage_t             d;
      stage_t             s;
      logic signed [35:0] es;
      assign s = st_q[k-1];
      always_comb begin
        d  = s;
        es = 36'(cfg_i.c1) + 36'(s.p1 >>> 16) + 36'(s.p2 >>> 16) + 36'(s.p3 >>> 16);
        if (es > 36'sh0_7FFF_FFFF) begin
          d.e = 32'sh7FFF_FFFF;
        end else if (es < -36'sh0_8000_0000) begin
          d.e = 32'sh8000_0000;
        end else begin
          d.e = es[31:0];
        end
        d.x = 17'h10000 - s.tr;
      end
      assign st_d[k] = d;
    end else if (k == ST_NRM) begin : g_nrm
      stage_t      d;
      stage_t      s;
      logic [46:0] nm;
      assign s = st_q[k-1];
      always_comb begin
        d    = s;
        d.lp = '0;
        for (int i = 0; i < 17; i++) begin
          if (s.x[i]) begin
            d.lp = 5'(i);
          end
        end
        nm     = {s.x, 30'b0} >> d.lp;
        d.lm   = nm[30:0];
        d.frac = '0;
      end
      assign st_d[k] = d;
    end else if (k < ST_Y1) begin : g_log
      // One fraction bit of log2 per stage by squaring the mantissa.
      stage_t      d;
      stage_t      s;
      logic [61:0] sq;
      logic [31:0] t;
      assign s = st_q[k-1];
      always_comb begin
        d      = s;
        sq     = 62'(s.lm) * 62'(s.lm);
        t      = sq[61:30];
        d.lm   = t[31] ? t[31:1] : t[30:0];
        d.frac = {s.frac[F-2:0], t[31]};
      end
      assign st_d[k] = d;
    end else if (k == ST_Y1) begin : g_y1
      stage_t               d;
      stage_t               s;
      logic [LW-1:0]        lval;
      logic signed [HW-1:0] lh;
      logic [XF-1:0]        ll;
      assign s = st_q[k-1];
      always_comb begin
        d    = s;
        lval = LW'(s.frac) - (LW'(5'd16 - s.lp) << F);
        lh   = $signed(lval[LW-1:XF]);
        ll   = lval[XF-1:0];
        d.pa = s.e * lh;
        d.pb = s.e * $signed({1'b0, ll});
      end
      assign st_d[k] = d;
    end else if (k == ST_Y2) begin : g_y2
      stage_t             d;
      stage_t             s;
      logic signed [YW-1:0] y;
      assign s = st_q[k-1];
      always_comb begin
        d      = s;
        y      = YW'(s.pa) + YW'(s.pb >>> XF);
        d.n    = $signed(y[YW-1:F]);
        d.f    = y[F-1:0];
        d.nbig = d.n >= $signed(NW'(48));
        d.em   = 31'(64'd1 << MF);
      end
      assign st_d[k] = d;
    end else if (k < ST_MUL) begin : g_exp
      // Multiply in 2^(2^-i) when fraction bit i of the power is set.
      localparam int unsigned        I    = k - ST_EXP0 + 1;
      localparam logic [30:0]        ROOT = 31'(rtpl_pkg::root_const(I));
      stage_t      d;
      stage_t      s;
      logic [61:0] pr;
      assign s = st_q[k-1];
      always_comb begin
        d  = s;
        pr = 62'(s.em) * 62'(ROOT);
        if (s.f[F-I]) begin
          d.em = pr[60:30];
        end
      end
      assign st_d[k] = d;
    end else if (k == ST_MUL) begin : g_mul
      stage_t     d;
      stage_t     s;
      logic [F:0] mant;
      assign s = st_q[k-1];
      always_comb begin
        d      = s;
        mant   = s.em[30:MF-F];
        d.prod = 64'(cfg_i.scale[30:0]) * 64'(mant);
      end
      assign st_d[k] = d;
    end else begin : g_out
      stage_t           d;
      stage_t           s;
      logic signed [NW:0] dd;
      logic [5:0]       kk;
      logic [63:0]      rs;
      logic [63:0]      rl;
      logic             ovf;
      assign s = st_q[k-1];
      always_comb begin
        d     = s;
        dd    = (NW+1)'(F) - (NW+1)'(s.n);
        kk    = 6'(s.n) - 6'(F);
        rs    = s.prod >> dd[5:0];
        rl    = s.prod << kk;
        ovf   = |(s.prod >> (6'd32 - kk));
        d.val = '0;
        d.sat = 1'b0;
        if (cfg_i.scale <= 0) begin
          d.sat = 1'b0;
        end else if (s.x == 17'd0) begin
          // Zero base: the power is 1, 0 or unbounded by the sign of e.
          if (s.e == 32'sd0) begin
            d.val = cfg_i.scale;
          end else if (s.e < 0) begin
            d.sat = 1'b1;
          end
        end else if (s.nbig) begin
          d.sat = 1'b1;
        end else if (s.n <= $signed(NW'(F))) begin
          if (dd <= $signed((NW+1)'(63))) begin
            d.val = rs[31:0];
            d.sat = |rs[63:32];
          end
        end else begin
          d.val = rl[31:0];
          d.sat = ovf;
        end
        if (d.sat) begin
          d.val = '1;
        end
      end
      assign st_d[k] = d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= (vin & en[NST-1:0]) | (v_q & ~en[NST-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NST; k++) begin
      if (en[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign out_valid_o      = v_q[NST-1];
  assign property_value_o = st_q[NST-1].val;
  assign saturated_o      = st_q[NST-1].sat;

endmodule
